/* design/wgc_pkg.sv */
// Shared constants, types and angle tables for the waypoint go-to controller.
// Used by the CORDIC cell, the squared-distance unit and the top level.
// No dependencies.
`default_nettype none

package wgc_pkg;

	localparam int POS_BITS     = 24;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int HEAD_BITS = 15;
	localparam int DTOL_W    = 16;
	localparam int ATOL_W    = 14;
	localparam int RATE_W    = 12;
	localparam int ANG_W     = RATE_W + 1;
	localparam int MODE_W    = 3;
	localparam int IDX_W     = 3;

	localparam int TABLE_LEN   = 24;
	localparam int STEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int STEP_W      = $clog2(TABLE_LEN);
	localparam int PRESCALE_SH = 6;

	localparam int DIFF_W = POS_BITS + 1;
	// Rotation gain and the diagonal need under three bits of headroom.
	localparam int CW     = DIFF_W + PRESCALE_SH + 3;
	localparam int ZW     = ANGLE_BITS + 4;
	localparam int ZSH    = ANGLE_BITS - 12;
	localparam int ATAN_W = ZW - ZSH;
	localparam int EH_W   = ATAN_W + 1;
	localparam int EY_W   = HEAD_BITS + 1;
	localparam int OP_W   = (DIFF_W > DTOL_W + 1) ? DIFF_W : DTOL_W + 1;
	localparam int SQ_W   = 2 * OP_W;
	localparam int CFG_W  = (POS_BITS > DTOL_W) ? POS_BITS : DTOL_W;

	localparam logic [IDX_W-1:0] REG_TARGET_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_HD = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIST_TOL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_ANGLE_TOL = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_SPD = 3'd5;
	localparam logic [IDX_W-1:0] REG_TURN_RATE = 3'd6;
	localparam logic [IDX_W-1:0] REG_STEER_RATE = 3'd7;

	localparam logic [MODE_W-1:0] MODE_ALIGN  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DRIVE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FINAL  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;

	// A heading error e steers left when 10*e exceeds 4096, i.e. e > floor(4096/10).
	localparam int STEER_THRESH = 4096 / 10;

	localparam int     RS        = 30 - ANGLE_BITS;
	localparam longint Q30_HALF  = longint'(1) <<< (RS - 1);
	localparam int     ZHALF     = (ZSH == 0) ? 0 : 2 ** (ZSH - 1);

	localparam longint ATAN_Q30 [TABLE_LEN] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};
	localparam longint HALF_PI_Q30 = 1686629713;
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'((HALF_PI_Q30 + Q30_HALF) >>> RS);

	typedef struct packed {
		logic                 vld;
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cdc_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [DTOL_W-1:0]        tol;
	} dist_req_t;

	typedef struct packed {
		logic busy;
		logic far;
	} dist_sts_t;

	// Elementary rotation angle of one step, rounded half up to the z grid.
	function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] idx);
		return ZW'((ATAN_Q30[idx] + Q30_HALF) >>> RS);
	endfunction

	// Accumulated angle rounded half up to 1/4096 rad.
	function automatic logic signed [ATAN_W-1:0] round_atan(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] zr;
		zr = z + ZW'(ZHALF);
		return ATAN_W'(zr >>> ZSH);
	endfunction

endpackage

`default_nettype wire

/* design/wgc_cordic_cell.sv */
// One vectoring step of the CORDIC atan2 chain, registered at its output.
// Depends on wgc_pkg for the cell data type and the angle table.
`default_nettype none

module wgc_cordic_cell import wgc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  cdc_t              din,
	output cdc_t              dout
);

	logic                 vld_q;
	logic                 zero_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] ang;
	logic                 y_pos;

	assign xs    = $signed(din.x) >>> step;
	assign ys    = $signed(din.y) >>> step;
	assign ang   = atan_step(step);
	assign y_pos = !din.y[CW-1] && (din.y != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (din.vld) begin
			zero_q <= din.zero;
			if (y_pos) begin
				x_q <= din.x + ys;
				y_q <= din.y - xs;
				z_q <= din.z + ang;
			end else begin
				x_q <= din.x - ys;
				y_q <= din.y + xs;
				z_q <= din.z - ang;
			end
		end
	end

	assign dout = '{vld: vld_q, zero: zero_q, x: x_q, y: y_q, z: z_q};

endmodule

`default_nettype wire

/* design/wgc_dist_sq.sv */
// Squared-distance test: dx^2 + dy^2 against tol^2 on one shared multiplier.
// Depends on wgc_pkg for the request and status structs.
`default_nettype none

module wgc_dist_sq import wgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dist_req_t req,
	output dist_sts_t sts
);

	typedef enum logic [2:0] {SQ_IDLE, SQ_DX, SQ_DY, SQ_TOL, SQ_CMP} sq_state_t;

	sq_state_t              state_q;
	logic                   far_q;
	logic signed [OP_W-1:0] op_q;
	logic [SQ_W-1:0]        prod_q;
	logic [SQ_W-1:0]        acc_q;
	logic signed [SQ_W-1:0] sq;

	assign sq = op_q * op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			far_q   <= 1'b0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (req.start) state_q <= SQ_DX;
				end
				SQ_DX:   state_q <= SQ_DY;
				SQ_DY:   state_q <= SQ_TOL;
				SQ_TOL:  state_q <= SQ_CMP;
				SQ_CMP: begin
					far_q   <= acc_q > prod_q;
					state_q <= SQ_IDLE;
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	// The requester must hold the request fields steady while the unit runs; the unit does not enforce this.
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: op_q <= OP_W'(req.dx);
			SQ_DX: begin
				prod_q <= sq;
				op_q   <= OP_W'(req.dy);
			end
			SQ_DY: begin
				acc_q  <= prod_q;
				prod_q <= sq;
				op_q   <= OP_W'(req.tol);
			end
			SQ_TOL: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= sq;
			end
			default: ;
		endcase
	end

	assign sts = '{busy: (state_q != SQ_IDLE), far: far_q};

endmodule

`default_nettype wire

/* design/waypoint_goto_controller_unit.sv */
// Go-to-goal bang-bang controller: top level with registers, sequencer and CORDIC chain.
// Depends on wgc_pkg, wgc_cordic_cell and wgc_dist_sq.
`default_nettype none

// Each pose beat yields exactly one command beat. The unit handles one beat at a
// time: item_stall stays high from acceptance until the command is loaded into
// the output register, passing the difference, launch, run, error and evaluate
// states in turn. The length of the CORDIC chain, one registered cell per step,
// sets how long the unit stays busy with a beat, and so the pose rate;
// the squared-distance multiply runs alongside it. A finished command waits in the
// output register, so the next pose beat can be taken while it does; the command
// for that beat is held back, with item_stall high, until the waiting one is taken.
// Configuration writes take effect at once and should be made while the unit is
// idle. After reset the goal is finished and commands read stop until start_goal.
module waypoint_goto_controller_unit import wgc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [IDX_W-1:0]            cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic signed [POS_BITS-1:0]  pos_x,
	input  logic signed [POS_BITS-1:0]  pos_y,
	input  logic signed [HEAD_BITS-1:0] heading,
	input  logic                        cancel_request,
	input  logic                        start_goal,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [RATE_W-1:0]           linear_speed,
	output logic signed [ANG_W-1:0]     angular_rate,
	output logic [MODE_W-1:0]           drive_mode,
	output logic                        goal_done
);

	typedef enum logic [2:0] {ST_IDLE, ST_DIFF, ST_LAUNCH, ST_RUN, ST_ERR, ST_EVAL} state_t;

	// Configuration registers.
	logic signed [POS_BITS-1:0]  target_x_q;
	logic signed [POS_BITS-1:0]  target_y_q;
	logic signed [HEAD_BITS-1:0] target_hd_q;
	logic [DTOL_W-1:0]           dist_tol_q;
	logic [ATOL_W-1:0]           angle_tol_q;
	logic [RATE_W-1:0]           drive_spd_q;
	logic [RATE_W-1:0]           turn_rate_q;
	logic [RATE_W-1:0]           steer_rate_q;

	state_t                      state_q;
	logic                        finished_q;
	logic                        out_vld_q;
	logic [RATE_W-1:0]           lin_q;
	logic signed [ANG_W-1:0]     ang_q;
	logic [MODE_W-1:0]           mode_q;
	logic                        done_q;

	logic signed [POS_BITS-1:0]  px_q;
	logic signed [POS_BITS-1:0]  py_q;
	logic signed [HEAD_BITS-1:0] hd_q;
	logic                        cancel_q;
	logic                        start_q;
	logic signed [DIFF_W-1:0]    dx_q;
	logic signed [DIFF_W-1:0]    dy_q;
	logic signed [ATAN_W-1:0]    atan_q;
	logic signed [EH_W-1:0]      err_head_q;
	logic signed [EY_W-1:0]      err_yaw_q;

	cdc_t                        chain [STEPS+1];
	cdc_t                        head;
	logic signed [CW-1:0]        x0;
	logic signed [CW-1:0]        y0;
	dist_req_t                   dist_req;
	dist_sts_t                   dist_sts;

	logic                        out_free;
	logic                        load;
	logic [EH_W-1:0]             abs_head;
	logic [EY_W-1:0]             abs_yaw;
	logic                        head_big;
	logic                        yaw_ok;
	logic                        far;
	logic [RATE_W-1:0]           nxt_lin;
	logic signed [ANG_W-1:0]     nxt_ang;
	logic [MODE_W-1:0]           nxt_mode;
	logic                        nxt_done;
	logic                        nxt_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q   <= '0;
			target_y_q   <= '0;
			target_hd_q  <= '0;
			dist_tol_q   <= DTOL_W'(287);
			angle_tol_q  <= ATOL_W'(429);
			drive_spd_q  <= RATE_W'(200);
			turn_rate_q  <= RATE_W'(350);
			steer_rate_q <= RATE_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_X:   target_x_q   <= cfg_data[POS_BITS-1:0];
				REG_TARGET_Y:   target_y_q   <= cfg_data[POS_BITS-1:0];
				REG_TARGET_HD:  target_hd_q  <= cfg_data[HEAD_BITS-1:0];
				REG_DIST_TOL:   dist_tol_q   <= cfg_data[DTOL_W-1:0];
				REG_ANGLE_TOL:  angle_tol_q  <= cfg_data[ATOL_W-1:0];
				REG_DRIVE_SPD:  drive_spd_q  <= cfg_data[RATE_W-1:0];
				REG_TURN_RATE:  turn_rate_q  <= cfg_data[RATE_W-1:0];
				REG_STEER_RATE: steer_rate_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign item_stall = (state_q != ST_IDLE);

	// Quadrant fold: a vector in the left half plane is turned by a quarter turn
	// so the vectoring steps only ever see x >= 0.
	always_comb begin
		x0        = CW'(dx_q) <<< PRESCALE_SH;
		y0        = CW'(dy_q) <<< PRESCALE_SH;
		head.vld  = (state_q == ST_LAUNCH);
		head.zero = (dx_q == '0) && (dy_q == '0);
		if (x0[CW-1]) begin
			if (!y0[CW-1]) begin
				head.x = y0;
				head.y = -x0;
				head.z = HALF_PI_Z;
			end else begin
				head.x = -y0;
				head.y = x0;
				head.z = -HALF_PI_Z;
			end
		end else begin
			head.x = x0;
			head.y = y0;
			head.z = '0;
		end
	end

	assign chain[0] = head;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		wgc_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(i)),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	assign dist_req = '{start: (state_q == ST_LAUNCH), dx: dx_q, dy: dy_q, tol: dist_tol_q};

	wgc_dist_sq u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dist_req),
		.sts    (dist_sts)
	);

	assign abs_head = err_head_q[EH_W-1] ? EH_W'(-err_head_q) : EH_W'(err_head_q);
	assign abs_yaw  = err_yaw_q[EY_W-1] ? EY_W'(-err_yaw_q) : EY_W'(err_yaw_q);
	assign head_big = abs_head > EH_W'(angle_tol_q);
	assign yaw_ok   = abs_yaw <= EY_W'(angle_tol_q);
	assign far      = dist_sts.far;

	always_comb begin
		nxt_lin  = '0;
		nxt_ang  = '0;
		nxt_mode = MODE_DONE;
		nxt_done = 1'b1;
		nxt_fin  = finished_q && !start_q;
		if (!nxt_fin) begin
			if (cancel_q) begin
				nxt_mode = MODE_CANCEL;
				nxt_fin  = 1'b1;
			end else if (!far && yaw_ok) begin
				nxt_fin = 1'b1;
			end else begin
				nxt_done = 1'b0;
				if (head_big && far) begin
					nxt_mode = MODE_ALIGN;
					nxt_ang  = (!err_head_q[EH_W-1] && (err_head_q != '0)) ?
						ANG_W'(turn_rate_q) : -ANG_W'(turn_rate_q);
				end else if (far) begin
					nxt_mode = MODE_DRIVE;
					nxt_lin  = drive_spd_q;
					nxt_ang  = (err_head_q > EH_W'(STEER_THRESH)) ?
						ANG_W'(steer_rate_q) : -ANG_W'(steer_rate_q);
				end else begin
					nxt_mode = MODE_FINAL;
					nxt_ang  = (!err_yaw_q[EY_W-1] && (err_yaw_q != '0)) ?
						ANG_W'(turn_rate_q) : -ANG_W'(turn_rate_q);
				end
			end
		end
	end

	assign out_free = !out_vld_q || !result_stall;
	assign load     = (state_q == ST_EVAL) && !dist_sts.busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			finished_q <= 1'b1;
			out_vld_q  <= 1'b0;
			lin_q      <= '0;
			ang_q      <= '0;
			mode_q     <= MODE_DONE;
			done_q     <= 1'b1;
		end else begin
			if (out_vld_q && !result_stall && !load) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_DIFF;
				end
				ST_DIFF:   state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= ST_RUN;
				ST_RUN: begin
					if (chain[STEPS].vld) state_q <= ST_ERR;
				end
				ST_ERR:    state_q <= ST_EVAL;
				ST_EVAL: begin
					if (load) begin
						out_vld_q  <= 1'b1;
						lin_q      <= nxt_lin;
						ang_q      <= nxt_ang;
						mode_q     <= nxt_mode;
						done_q     <= nxt_done;
						finished_q <= nxt_fin;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			px_q     <= pos_x;
			py_q     <= pos_y;
			hd_q     <= heading;
			cancel_q <= cancel_request;
			start_q  <= start_goal;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= DIFF_W'(target_x_q) - DIFF_W'(px_q);
			dy_q <= DIFF_W'(target_y_q) - DIFF_W'(py_q);
		end
		if (state_q == ST_RUN && chain[STEPS].vld) begin
			atan_q <= chain[STEPS].zero ? '0 : round_atan(chain[STEPS].z);
		end
		if (state_q == ST_ERR) begin
			err_head_q <= EH_W'(atan_q) - EH_W'(hd_q);
			err_yaw_q  <= EY_W'(target_hd_q) - EY_W'(hd_q);
		end
	end

	assign result_valid = out_vld_q;
	assign linear_speed = lin_q;
	assign angular_rate = ang_q;
	assign drive_mode   = mode_q;
	assign goal_done    = done_q;

`ifndef SYNTHESIS
	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain[STEPS].vld |-> state_q == ST_RUN)
		else $error("CORDIC result arrived outside the run state");

	a_dist_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAUNCH |=> dist_sts.busy)
		else $error("distance unit did not start with the CORDIC chain");

	a_done_modes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> goal_done == (drive_mode == MODE_CANCEL || drive_mode == MODE_DONE))
		else $error("goal_done disagrees with drive_mode");

	a_stop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && goal_done |-> linear_speed == '0 && angular_rate == '0)
		else $error("finished goal commands motion");

	a_lin_drive_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && drive_mode != MODE_DRIVE |-> linear_speed == '0)
		else $error("forward speed outside drive mode");
`endif

endmodule

`default_nettype wire

/* dv/waypoint_goto_controller_unit_tb.sv */
// Self-checking bench for the waypoint go-to controller: a directed pose table, then random poses.
// Every command beat is compared against an expectation: the directed table's where it gives one, else a local model.
// Depends on wgc_pkg and waypoint_goto_controller_unit.
`default_nettype none

module waypoint_goto_controller_unit_tb import wgc_pkg::*;;

	typedef struct packed {
		logic signed [POS_BITS-1:0]  x;
		logic signed [POS_BITS-1:0]  y;
		logic signed [HEAD_BITS-1:0] hd;
		logic                        cancel;
		logic                        start;
	} pose_t;

	typedef struct packed {
		logic [RATE_W-1:0]       lin;
		logic signed [ANG_W-1:0] ang;
		logic [MODE_W-1:0]       mode;
		logic                    done;
	} cmd_t;

	typedef struct packed {
		pose_t pose;
		logic  typed;
		cmd_t  want;
	} probe_t;

	localparam cmd_t DONE_CMD   = '{lin: '0, ang: '0, mode: MODE_DONE, done: 1'b1};
	localparam cmd_t CANCEL_CMD = '{lin: '0, ang: '0, mode: MODE_CANCEL, done: 1'b1};
	localparam cmd_t NO_CMD     = '0;

	// Arctangent of 2^-i in Q30 radians, plus pi/2 for the half-plane flip.
	localparam int     BEARING_STEPS    = 16;
	localparam int     Z_FRAC           = 16;
	localparam longint QUARTER_TURN_Q30 = 1686629713;
	localparam longint ARC_Q30 [BEARING_STEPS] = '{
		843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149,
		1048576, 524288, 262144, 131072, 65536, 32768
	};

	localparam int FEED_BATCH = 150;
	localparam int GOAL_SETS  = 6;

	// Directed poses under the reset configuration (target at the origin).
	localparam probe_t PROBES [24] = '{
		'{'{100000, 0, 0, 0, 0}, 1, DONE_CMD},
		'{'{0, 0, 0, 0, 0}, 1, DONE_CMD},
		'{'{0, 0, 0, 1, 1}, 1, CANCEL_CMD},
		'{'{5000, 5000, 100, 1, 0}, 1, DONE_CMD},
		'{'{0, 0, 0, 0, 1}, 1, DONE_CMD},
		'{'{200, -100, 0, 0, 1}, 1, DONE_CMD},
		'{'{287, 0, 0, 0, 1}, 1, DONE_CMD},
		'{'{288, 0, 0, 0, 1}, 0, NO_CMD},
		'{'{0, 0, 430, 0, 0}, 0, NO_CMD},
		'{'{0, 0, -429, 0, 0}, 1, DONE_CMD},
		'{'{0, 0, -430, 0, 1}, 0, NO_CMD},
		'{'{-8388608, -8388608, -16384, 0, 0}, 0, NO_CMD},
		'{'{8388607, 8388607, 12868, 0, 0}, 0, NO_CMD},
		'{'{-409600, 0, 0, 0, 0}, 0, NO_CMD},
		'{'{-409600, 0, -410, 0, 0}, 0, NO_CMD},
		'{'{-409600, 0, -409, 0, 0}, 0, NO_CMD},
		'{'{-409600, 0, -429, 0, 0}, 0, NO_CMD},
		'{'{-409600, 0, -430, 0, 0}, 0, NO_CMD},
		'{'{0, -8388608, 0, 0, 0}, 0, NO_CMD},
		'{'{8388607, -8388608, -12868, 0, 0}, 0, NO_CMD},
		'{'{100000, 0, 0, 1, 0}, 1, CANCEL_CMD},
		'{'{0, 0, 0, 0, 0}, 1, DONE_CMD},
		'{'{0, 0, 16383, 0, 1}, 0, NO_CMD},
		'{'{0, 0, -12868, 1, 1}, 1, CANCEL_CMD}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [IDX_W-1:0]            cfg_index;
	logic [CFG_W-1:0]            cfg_data;
	logic                        item_valid;
	logic                        item_stall;
	logic signed [POS_BITS-1:0]  pos_x;
	logic signed [POS_BITS-1:0]  pos_y;
	logic signed [HEAD_BITS-1:0] heading;
	logic                        cancel_request;
	logic                        start_goal;
	logic                        result_valid;
	logic                        result_stall;
	logic [RATE_W-1:0]           linear_speed;
	logic signed [ANG_W-1:0]     angular_rate;
	logic [MODE_W-1:0]           drive_mode;
	logic                        goal_done;

	// Mirror of the goal registers and of the finished flag.
	longint goal_x = 0, goal_y = 0, goal_hd = 0;
	longint dist_tol = 287, ang_tol = 429;
	longint speed_fwd = 200, rate_turn = 350, rate_steer = 100;
	bit     goal_finished = 1'b1;

	logic [CFG_W-1:0] goal_regs [8];
	cmd_t             cmd_due [$];
	int               mismatches = 0;
	int               feed_gap_pct = 32;
	int               stall_pct = 48;

	waypoint_goto_controller_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.heading        (heading),
		.cancel_request (cancel_request),
		.start_goal     (start_goal),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.linear_speed   (linear_speed),
		.angular_rate   (angular_rate),
		.drive_mode     (drive_mode),
		.goal_done      (goal_done)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint jitter(longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	// atan2(dy, dx) in 1/4096 rad; the left half-plane is first rotated by a quarter turn.
	function automatic longint bearing_atan2(longint dy, longint dx);
		longint x, y, z, t, a;
		int i;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 64;
		y = dy * 64;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = half_up(QUARTER_TURN_Q30, 30 - Z_FRAC);
			end else begin
				x = -y;
				y = t;
				z = -half_up(QUARTER_TURN_Q30, 30 - Z_FRAC);
			end
		end
		for (i = 0; i < BEARING_STEPS; i++) begin
			a = half_up(ARC_Q30[i], 30 - Z_FRAC);
			t = x;
			if (y > 0) begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				z = z + a;
			end else begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				z = z - a;
			end
		end
		return half_up(z, Z_FRAC - 12);
	endfunction

	function automatic cmd_t steer_decision(pose_t p);
		longint dx, dy, hd, err_h, err_y, abs_h, abs_y;
		longint unsigned d2, tol2;
		bit far;
		cmd_t c;
		c = DONE_CMD;
		if (p.start)
			goal_finished = 1'b0;
		if (!goal_finished) begin
			hd = longint'($signed(p.hd));
			dx = goal_x - longint'($signed(p.x));
			dy = goal_y - longint'($signed(p.y));
			err_h = bearing_atan2(dy, dx) - hd;
			err_y = goal_hd - hd;
			abs_h = (err_h < 0) ? -err_h : err_h;
			abs_y = (err_y < 0) ? -err_y : err_y;
			d2 = longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy));
			tol2 = dist_tol * dist_tol;
			far = d2 > tol2;
			if (p.cancel) begin
				c.mode = MODE_CANCEL;
				goal_finished = 1'b1;
			end else if (!far && abs_y <= ang_tol) begin
				goal_finished = 1'b1;
			end else begin
				c.done = 1'b0;
				if (abs_h > ang_tol && far) begin
					c.mode = MODE_ALIGN;
					c.ang = ANG_W'((err_h > 0) ? rate_turn : -rate_turn);
				end else if (far) begin
					c.mode = MODE_DRIVE;
					c.lin = RATE_W'(speed_fwd);
					c.ang = ANG_W'((err_h * 10 > 4096) ? rate_steer : -rate_steer);
				end else begin
					c.mode = MODE_FINAL;
					c.ang = ANG_W'((err_y > 0) ? rate_turn : -rate_turn);
				end
			end
		end
		return c;
	endfunction

	// Most poses land near the goal or on a heading near the bearing, so every mode is reached.
	function automatic pose_t pick_pose();
		pose_t p;
		longint x, y, h;
		int sel;
		sel = $urandom_range(99);
		if (sel < 35) begin
			x = goal_x + jitter(dist_tol + 1);
			y = goal_y + jitter(dist_tol + 1);
		end else if (sel < 75) begin
			x = goal_x + jitter(131072);
			y = goal_y + jitter(131072);
		end else begin
			x = $urandom;
			y = $urandom;
		end
		p.x = POS_BITS'(x);
		p.y = POS_BITS'(y);
		sel = $urandom_range(99);
		if (sel < 35)
			h = goal_hd + jitter(2 * ang_tol + 2);
		else if (sel < 70)
			h = bearing_atan2(goal_y - longint'(p.y), goal_x - longint'(p.x)) + jitter(700);
		else if (sel < 90)
			h = jitter(12868);
		else
			h = $urandom;
		p.hd = HEAD_BITS'(h);
		p.cancel = ($urandom_range(99) < 4);
		p.start = ($urandom_range(99) < (goal_finished ? 60 : 4));
		return p;
	endfunction

	task automatic send_pose(pose_t p, bit typed, cmd_t want);
		cmd_t c;
		while ($urandom_range(99) < feed_gap_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		pos_x <= p.x;
		pos_y <= p.y;
		heading <= p.hd;
		cancel_request <= p.cancel;
		start_goal <= p.start;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		c = steer_decision(p);
		cmd_due.push_back(typed ? want : c);
	endtask

	task automatic drain_commands();
		@(negedge clk);
		item_valid <= 1'b0;
		while (cmd_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic program_goal();
		int r;
		for (r = 0; r < 8; r++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(r);
			cfg_data <= goal_regs[r];
			case (IDX_W'(r))
				REG_TARGET_X:   goal_x = longint'($signed(goal_regs[r][POS_BITS-1:0]));
				REG_TARGET_Y:   goal_y = longint'($signed(goal_regs[r][POS_BITS-1:0]));
				REG_TARGET_HD:  goal_hd = longint'($signed(goal_regs[r][HEAD_BITS-1:0]));
				REG_DIST_TOL:   dist_tol = longint'(goal_regs[r][DTOL_W-1:0]);
				REG_ANGLE_TOL:  ang_tol = longint'(goal_regs[r][ATOL_W-1:0]);
				REG_DRIVE_SPD:  speed_fwd = longint'(goal_regs[r][RATE_W-1:0]);
				REG_TURN_RATE:  rate_turn = longint'(goal_regs[r][RATE_W-1:0]);
				REG_STEER_RATE: rate_steer = longint'(goal_regs[r][RATE_W-1:0]);
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic flag_mismatch(string why, cmd_t want, cmd_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected lin=%0d ang=%0d mode=%0d done=%0d,",
				" got lin=%0d ang=%0d mode=%0d done=%0d"},
				why, want.lin, want.ang, want.mode, want.done,
				got.lin, got.ang, got.mode, got.done);
	endtask

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Each accepted command beat is matched against the oldest pending prediction.
	always @(posedge clk) begin
		cmd_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = {linear_speed, angular_rate, drive_mode, goal_done};
			if (cmd_due.size() == 0) begin
				flag_mismatch("command beat with nothing pending", NO_CMD, got);
			end else begin
				if (got !== cmd_due[0])
					flag_mismatch("command beat mismatch", cmd_due[0], got);
				void'(cmd_due.pop_front());
			end
		end
	end

	initial begin
		int k, ph, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		heading = '0;
		cancel_request = 1'b0;
		start_goal = 1'b0;
		result_stall = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < $size(PROBES); k++)
			send_pose(PROBES[k].pose, PROBES[k].typed, PROBES[k].want);

		n = $size(PROBES);
		for (ph = 0; ph < GOAL_SETS; ph++) begin
			drain_commands();
			case (ph)
				0: begin
					goal_regs[REG_TARGET_X] = CFG_W'(40960);
					goal_regs[REG_TARGET_Y] = CFG_W'(-20480);
					goal_regs[REG_TARGET_HD] = CFG_W'(1000);
					goal_regs[REG_DIST_TOL] = CFG_W'(287);
					goal_regs[REG_ANGLE_TOL] = CFG_W'(429);
					goal_regs[REG_DRIVE_SPD] = CFG_W'(200);
					goal_regs[REG_TURN_RATE] = CFG_W'(350);
					goal_regs[REG_STEER_RATE] = CFG_W'(100);
				end
				1: begin
					goal_regs[REG_TARGET_X] = CFG_W'(8388607);
					goal_regs[REG_TARGET_Y] = CFG_W'(8388607);
					goal_regs[REG_TARGET_HD] = CFG_W'(12868);
					goal_regs[REG_DIST_TOL] = CFG_W'(65535);
					goal_regs[REG_ANGLE_TOL] = CFG_W'(12868);
					goal_regs[REG_DRIVE_SPD] = CFG_W'(4095);
					goal_regs[REG_TURN_RATE] = CFG_W'(4095);
					goal_regs[REG_STEER_RATE] = CFG_W'(4095);
				end
				2: begin
					goal_regs[REG_TARGET_X] = CFG_W'(-8388608);
					goal_regs[REG_TARGET_Y] = CFG_W'(-8388608);
					goal_regs[REG_TARGET_HD] = CFG_W'(-12868);
					goal_regs[REG_DIST_TOL] = '0;
					goal_regs[REG_ANGLE_TOL] = '0;
					goal_regs[REG_DRIVE_SPD] = '0;
					goal_regs[REG_TURN_RATE] = '0;
					goal_regs[REG_STEER_RATE] = '0;
				end
				3: begin
					// Raw values past the stated ranges, with junk above the width of the heading, tolerance and rate registers.
					goal_regs[REG_TARGET_X] = '0;
					goal_regs[REG_TARGET_Y] = '0;
					goal_regs[REG_TARGET_HD] = 24'hFFC000;
					goal_regs[REG_DIST_TOL] = 24'hAB1234;
					goal_regs[REG_ANGLE_TOL] = 24'h00FFFF;
					goal_regs[REG_DRIVE_SPD] = 24'h555AAA;
					goal_regs[REG_TURN_RATE] = 24'hAAA555;
					goal_regs[REG_STEER_RATE] = 24'hFFF001;
				end
				default: begin
					goal_regs[REG_TARGET_X] = CFG_W'($urandom);
					goal_regs[REG_TARGET_Y] = CFG_W'($urandom);
					goal_regs[REG_TARGET_HD] = CFG_W'(jitter(12868));
					goal_regs[REG_DIST_TOL] = CFG_W'($urandom_range(0, 3000));
					goal_regs[REG_ANGLE_TOL] = CFG_W'($urandom_range(0, 1500));
					goal_regs[REG_DRIVE_SPD] = CFG_W'($urandom_range(0, 4095));
					goal_regs[REG_TURN_RATE] = CFG_W'($urandom_range(0, 4095));
					goal_regs[REG_STEER_RATE] = CFG_W'($urandom_range(0, 4095));
				end
			endcase
			program_goal();
			for (k = 0; k < FEED_BATCH; k++) begin
				feed_gap_pct = (n < 300) ? 32 : ((n < 600) ? 48 : 0);
				stall_pct = (n < 300) ? 48 : ((n < 600) ? 32 : 0);
				if ($urandom_range(59) == 0)
					drain_commands();
				send_pose(pick_pose(), 1'b0, NO_CMD);
				n++;
			end
		end

		drain_commands();
		if (mismatches == 0 && cmd_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
design/wgc_pkg.sv
design/wgc_cordic_cell.sv
design/wgc_dist_sq.sv
design/waypoint_goto_controller_unit.sv
dv/waypoint_goto_controller_unit_tb.sv
